// ===== hdl/u8u16_pkg.sv =====
`timescale 1ns / 1ps
// Package for the UTF-8 to UTF-16 decoder: job type passed from front to back,
// error codes and surrogate tags. No dependencies.

package u8u16_pkg;

  // Error codes carried in the error_code field of a result.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_LEAD = 2'd1;
  localparam logic [1:0] ERR_TRUNC    = 2'd2;
  localparam logic [1:0] ERR_RANGE    = 2'd3;

  // Top six bits of the high and low surrogate halves (0xD800, 0xDC00).
  localparam logic [5:0] SURR_HI_TAG = 6'b110110;
  localparam logic [5:0] SURR_LO_TAG = 6'b110111;

  // Largest code point and the offset removed before splitting into a pair.
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] CP_PAIR_OFS = 21'h010000;

  typedef enum logic [1:0] {
    JOB_UNIT = 2'd0,
    JOB_PAIR = 2'd1,
    JOB_ERR  = 2'd2
  } job_kind_t;

  // One finished code point or error. For a unit, data[15:0] is the unit;
  // for a pair, data is the code point minus 0x10000.
  typedef struct packed {
    job_kind_t   kind;
    logic [19:0] data;
    logic [1:0]  err;
    logic        last;
  } job_t;

endpackage

// ===== hdl/u8u16_ifs.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the UTF-8 to UTF-16 decoder: byte input and unit output.
// Depends on nothing.

interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic [1:0]  error_code;
  logic        run_end;
  logic        string_end;

  modport source (output valid, output code_unit, output error_code, output run_end,
                  output string_end, input ready);
  modport sink   (input valid, input code_unit, input error_code, input run_end,
                  input string_end, output ready);
endinterface

// ===== hdl/u8u16_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks the partial code point and emits jobs.
// Depends on u8u16_pkg and u8u16_in_if.

module u8u16_front
  import u8u16_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  u8u16_in_if.sink         in_ch,
  input  logic             q_full,
  output logic             push,
  output job_t             push_job
);

  logic [20:0] pp_r, pp_nxt;
  logic [1:0]  due_r, due_nxt;
  logic        drop_r, drop_nxt;
  logic        accept;
  logic        job_hit;
  logic [7:0]  b;
  logic        last;
  logic [20:0] cont_pp;
  logic [20:0] pair_v;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.data_byte;
  assign last        = in_ch.final_byte;
  assign cont_pp     = {pp_r[14:0], b[5:0]};
  assign pair_v      = cont_pp - CP_PAIR_OFS;

  always_comb begin
    pp_nxt        = pp_r;
    due_nxt       = due_r;
    drop_nxt      = drop_r;
    job_hit       = 1'b0;
    push_job.kind = JOB_UNIT;
    push_job.data = 20'd0;
    push_job.err  = ERR_NONE;
    push_job.last = last;
    if (drop_r) begin
      if (last) begin
        drop_nxt = 1'b0;
      end
    end else if (due_r == 2'd0) begin
      priority if (b[7] == 1'b0) begin
        job_hit       = 1'b1;
        push_job.data = {12'd0, b};
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
        if (last) begin
          job_hit       = 1'b1;
          push_job.kind = JOB_ERR;
          push_job.err  = ERR_TRUNC;
        end else begin
          priority if (b[7:5] == 3'b110) begin
            pp_nxt  = {16'd0, b[4:0]};
            due_nxt = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            pp_nxt  = {17'd0, b[3:0]};
            due_nxt = 2'd2;
          end else begin
            pp_nxt  = {18'd0, b[2:0]};
            due_nxt = 2'd3;
          end
        end
      end else begin
        job_hit       = 1'b1;
        push_job.kind = JOB_ERR;
        push_job.err  = ERR_BAD_LEAD;
        drop_nxt      = !last;
      end
    end else begin
      // Continuation byte: only its low six bits are used.
      if (due_r == 2'd1) begin
        pp_nxt  = 21'd0;
        due_nxt = 2'd0;
        job_hit = 1'b1;
        priority if (cont_pp[20:16] == 5'd0) begin
          push_job.data = {4'd0, cont_pp[15:0]};
        end else if (cont_pp <= CP_MAX) begin
          push_job.kind = JOB_PAIR;
          push_job.data = pair_v[19:0];
        end else begin
          push_job.kind = JOB_ERR;
          push_job.err  = ERR_RANGE;
          drop_nxt      = !last;
        end
      end else if (last) begin
        pp_nxt        = 21'd0;
        due_nxt       = 2'd0;
        job_hit       = 1'b1;
        push_job.kind = JOB_ERR;
        push_job.err  = ERR_TRUNC;
      end else begin
        pp_nxt  = cont_pp;
        due_nxt = due_r - 2'd1;
      end
    end
  end

  assign push = accept && job_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r   <= 21'd0;
      due_r  <= 2'd0;
      drop_r <= 1'b0;
    end else if (accept) begin
      pp_r   <= pp_nxt;
      due_r  <= due_nxt;
      drop_r <= drop_nxt;
    end
  end

  // While dropping, no sequence can be in progress.
  a_drop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> (due_r == 2'd0 && pp_r == 21'd0))
    else $error("front: dropping with a sequence in progress");

  // A byte marked last always leaves the front at its reset state.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (due_r == 2'd0 && !drop_r && pp_r == 21'd0))
    else $error("front: state not cleared after last byte");

endmodule

// ===== hdl/u8u16_queue.sv =====
`timescale 1ns / 1ps
// Small job queue between the front and back ends.
// Depends on u8u16_pkg.

module u8u16_queue
  import u8u16_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue: push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue: pop from empty queue");

endmodule

// ===== hdl/u8u16_back.sv =====
`timescale 1ns / 1ps
// Back end: turns jobs into UTF-16 result beats, splitting surrogate pairs.
// Depends on u8u16_pkg and u8u16_out_if.

module u8u16_back
  import u8u16_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  job_t         head,
  input  logic         empty,
  output logic         pop,
  u8u16_out_if.source  out_ch
);

  logic        out_valid_r;
  logic [15:0] out_unit_r;
  logic [1:0]  out_err_r;
  logic        out_rend_r;
  logic        out_send_r;
  logic        pend_r;
  logic [9:0]  pend_low_r;
  logic        pend_last_r;
  logic        out_free;

  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = out_free && !pend_r && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (out_free) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else begin
        out_valid_r <= !empty;
        pend_r      <= !empty && (head.kind == JOB_PAIR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_r) begin
        out_unit_r <= {SURR_LO_TAG, pend_low_r};
        out_err_r  <= ERR_NONE;
        out_rend_r <= 1'b1;
        out_send_r <= pend_last_r;
      end else begin
        pend_low_r  <= head.data[9:0];
        pend_last_r <= head.last;
        unique case (head.kind)
          JOB_PAIR: begin
            out_unit_r <= {SURR_HI_TAG, head.data[19:10]};
            out_err_r  <= ERR_NONE;
            out_rend_r <= 1'b0;
            out_send_r <= 1'b0;
          end
          JOB_ERR: begin
            out_unit_r <= 16'd0;
            out_err_r  <= head.err;
            out_rend_r <= 1'b1;
            out_send_r <= 1'b1;
          end
          default: begin
            out_unit_r <= head.data[15:0];
            out_err_r  <= ERR_NONE;
            out_rend_r <= 1'b1;
            out_send_r <= head.last;
          end
        endcase
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_unit  = out_unit_r;
  assign out_ch.error_code = out_err_r;
  assign out_ch.run_end    = out_rend_r;
  assign out_ch.string_end = out_send_r;

  // A pending low half always sits behind a shown high half.
  a_pend_behind_high: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (out_valid_r && !out_rend_r && out_unit_r[15:10] == SURR_HI_TAG))
    else $error("back: low half pending without high half shown");

  // An error beat closes its byte's run and the string.
  a_err_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r != ERR_NONE) |-> (out_rend_r && out_send_r))
    else $error("back: error beat does not close the string");

  // The string can only end on the last beat of a byte's run.
  a_send_on_rend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_send_r) |-> out_rend_r)
    else $error("back: string_end without run_end");

endmodule

// ===== hdl/utf8_to_utf16_decoder.sv =====
`timescale 1ns / 1ps
//  Channel   Dir  Handshake      Beat payload
//  in_ch     in   valid/ready    data_byte[7:0], final_byte
//  out_ch    out  valid/ready    code_unit[15:0], error_code[1:0], run_end, string_end
//
//  The front end accepts a new byte every cycle as long as the job queue has
//  room. Each job leaves the back end as one result beat, or two for a surrogate
//  pair, so the back end's single output register sets the peak of one result
//  beat per cycle. A byte's job passes through the job queue into the back end's
//  output register before its first result beat is shown. Reset is synchronous
//  on rst_n and clears the decoding state, the queue pointers and the output
//  valid flag. A stall on out_ch fills the queue first and only then lowers in_ch.ready.
// Top level of the UTF-8 to UTF-16 decoder.
// Depends on u8u16_pkg, u8u16_ifs, u8u16_front, u8u16_queue and u8u16_back.

module utf8_to_utf16_decoder
  import u8u16_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  u8u16_in_if.sink     in_ch,
  u8u16_out_if.source  out_ch
);

  // Jobs carry one finished code point or one error from front to back.
  logic q_push;
  job_t q_push_job;
  logic q_pop;
  job_t q_head;
  logic q_full;
  logic q_empty;

  // The front end decodes lead and continuation bytes. It pushes a job only
  // when a byte finishes a code point or raises an error; all other bytes just
  // update the partial code point, the count of bytes due or the drop flag.
  u8u16_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (q_push_job)
  );

  // The queue lets the front keep taking bytes while the back end emits both
  // halves of a surrogate pair or waits on a stalled consumer.
  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // The back end turns each job into one or two result beats.
  u8u16_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .empty  (q_empty),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== verif/utf8_to_utf16_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 to UTF-16 decoder: byte strings in, code units out.
// Depends on u8u16_pkg, the channel interfaces in u8u16_ifs and utf8_to_utf16_decoder.

module utf8_to_utf16_decoder_test
  import u8u16_pkg::*;
;

  // A hang is assumed once this many cycles pass with no beat on either channel.
  // The longest legal gap is the deliberate receiver hold below, plus short stalls.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_BYTES    = 270;
  localparam int DRAIN_CYCLES   = 20;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } utf8_byte_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [1:0]  error_code;
    logic        run_end;
    logic        string_end;
  } utf16_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  u8u16_in_if  in_bus ();
  u8u16_out_if out_bus ();

  utf8_to_utf16_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be offered, and the units the decoder owes us, oldest first.
  utf8_byte_t  pending_bytes[$];
  utf16_beat_t expected_units[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int bytes_queued = 0;
  int bytes_accepted = 0;
  int n_errors = 0;

  // Decoder state as the predictor sees it: the code point gathered so far, the
  // continuation bytes still owed, and whether the rest of the string is thrown away.
  logic [20:0] cp_acc = '0;
  logic [1:0]  cont_left = '0;
  logic        skipping = 1'b0;

  function automatic void post_unit(logic [15:0] code, logic [1:0] err, logic rend,
                                    logic send);
    utf16_beat_t beat;
    beat = '{code_unit: code, error_code: err, run_end: rend, string_end: send};
    expected_units.insert(expected_units.size(), beat);
  endfunction

  // An error result always closes the string. If the offending byte is not the
  // last one, everything up to the marked last byte is discarded without output.
  function automatic void flag_error(logic [1:0] err, logic fin);
    post_unit(16'h0000, err, 1'b1, 1'b1);
    cp_acc = '0;
    cont_left = '0;
    skipping = !fin;
  endfunction

  // A finished code point becomes one unit, a surrogate pair, or a range error.
  function automatic void emit_point(logic [20:0] cp, logic fin);
    logic [20:0] ofs;
    cp_acc = '0;
    cont_left = '0;
    if (cp <= 21'h00FFFF) begin
      post_unit(cp[15:0], ERR_NONE, 1'b1, fin);
    end else if (cp <= CP_MAX) begin
      ofs = cp - CP_PAIR_OFS;
      post_unit({SURR_HI_TAG, ofs[19:10]}, ERR_NONE, 1'b0, 1'b0);
      post_unit({SURR_LO_TAG, ofs[9:0]}, ERR_NONE, 1'b1, fin);
    end else begin
      flag_error(ERR_RANGE, fin);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic fin);
    logic [1:0] due;
    if (skipping) begin
      if (fin) begin
        skipping = 1'b0;
        cp_acc = '0;
        cont_left = '0;
      end
      return;
    end
    if (cont_left == 2'd0) begin
      // A lead byte is expected here.
      if (b[7] == 1'b0) begin
        emit_point({13'd0, b}, fin);
        return;
      end
      if (b[7:5] == 3'b110) begin
        cp_acc = {16'd0, b[4:0]};
        due = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        cp_acc = {17'd0, b[3:0]};
        due = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        cp_acc = {18'd0, b[2:0]};
        due = 2'd3;
      end else begin
        flag_error(ERR_BAD_LEAD, fin);
        return;
      end
      // A multi-byte lead that ends the string is a cut-off sequence.
      if (fin) flag_error(ERR_TRUNC, fin);
      else cont_left = due;
      return;
    end
    // Continuation bytes are not checked; only their low six bits count.
    cp_acc = {cp_acc[14:0], b[5:0]};
    cont_left = cont_left - 2'd1;
    if (cont_left == 2'd0) emit_point(cp_acc, fin);
    else if (fin) flag_error(ERR_TRUNC, fin);
  endfunction

  function automatic void push_byte(logic [7:0] b, logic fin);
    utf8_byte_t item;
    item = '{value: b, last: fin};
    pending_bytes.insert(pending_bytes.size(), item);
    bytes_queued++;
  endfunction

  function automatic logic [7:0] cont_byte();
    // Mostly well-formed 10xxxxxx bytes, sometimes any value at all.
    if ($urandom_range(99) < 5) return 8'($urandom_range(255));
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // Builds one random string from 1 to 6 code points of all four lengths, then
  // sometimes breaks it: a cut-off tail, a bad lead byte on a code point boundary,
  // or plain noise. The last byte carries the end-of-string mark.
  task automatic queue_string();
    logic [7:0] seq[$];
    int starts[$];
    int n_points, kind, len, m, tail;
    logic [7:0] lead, bad;
    n_points = $urandom_range(1, 6);
    for (int i = 0; i < n_points; i++) begin
      starts.insert(starts.size(), seq.size());
      kind = $urandom_range(99);
      if (kind < 35) begin
        seq.insert(seq.size(), 8'($urandom_range(127)));
        continue;
      end else if (kind < 60) begin
        lead = 8'hC0 | 8'($urandom_range(31));
        len = 2;
      end else if (kind < 80) begin
        lead = 8'hE0 | 8'($urandom_range(15));
        len = 3;
      end else begin
        // F0..F3 always fit; F4..F7 mostly exceed the largest code point.
        lead = ($urandom_range(9) < 9) ? 8'hF0 | 8'($urandom_range(3))
                                       : 8'hF4 | 8'($urandom_range(3));
        len = 4;
      end
      seq.insert(seq.size(), lead);
      for (int j = 1; j < len; j++) seq.insert(seq.size(), cont_byte());
    end

    m = $urandom_range(99);
    if (m < 10) begin
      tail = seq.size() - starts[starts.size() - 1];
      if (tail > 1) begin
        repeat ($urandom_range(1, tail - 1)) seq.delete(seq.size() - 1);
      end
    end else if (m < 18) begin
      bad = ($urandom_range(1) == 0) ? 8'h80 | 8'($urandom_range(63))
                                     : 8'hF8 | 8'($urandom_range(7));
      seq.insert(starts[$urandom_range(starts.size() - 1)], bad);
    end else if (m < 23) begin
      seq.delete();
      repeat ($urandom_range(1, 8)) seq.insert(seq.size(), 8'($urandom_range(255)));
    end

    foreach (seq[k]) push_byte(seq[k], k == seq.size() - 1);
  endtask

  // Hand-picked strings: the extremes of every form and each error path.
  task automatic queue_directed();
    push_byte(8'h00, 1'b1);                         // smallest ASCII, alone
    push_byte(8'h7F, 1'b0);                         // largest ASCII
    push_byte(8'hDF, 1'b0);                         // largest two-byte point
    push_byte(8'hBF, 1'b1);
    push_byte(8'hEF, 1'b0);                         // largest single unit
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b1);
    push_byte(8'hF0, 1'b0);                         // smallest surrogate pair
    push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b1);
    push_byte(8'hF4, 1'b0);                         // largest legal code point
    push_byte(8'h8F, 1'b0);
    push_byte(8'hBF, 1'b0);
    push_byte(8'hBF, 1'b1);
    push_byte(8'hF4, 1'b0);                         // one past the top, then dropped bytes
    push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h41, 1'b1);
    push_byte(8'h80, 1'b1);                         // stray continuation as lead, last
    push_byte(8'hFF, 1'b0);                         // invalid lead, then dropped byte
    push_byte(8'h12, 1'b1);
    push_byte(8'hC3, 1'b1);                         // multi-byte lead that ends the string
    push_byte(8'hE2, 1'b0);                         // sequence cut off midway
    push_byte(8'h82, 1'b1);
  endtask

  // Driver: a beat is taken at an edge where valid and ready are both high. When
  // the slot is free it offers the next byte, or idles at the phase's rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.data_byte <= 8'h00;
      in_bus.final_byte <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        decode_byte(in_bus.data_byte, in_bus.final_byte);
        bytes_accepted <= bytes_accepted + 1;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_bus.valid <= 1'b1;
          in_bus.data_byte <= pending_bytes[0].value;
          in_bus.final_byte <= pending_bytes[0].last;
          void'(pending_bytes.pop_front());
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every unit beat is matched against the oldest expected unit.
  // On request it also holds ready low for a long stretch so the decoder's
  // queue fills up and its input stalls.
  int hold_left = 0;
  int holds_served = 0;

  always @(posedge clk) begin
    utf16_beat_t got, want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      hold_left <= 0;
      holds_served <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = '{code_unit: out_bus.code_unit, error_code: out_bus.error_code,
                run_end: out_bus.run_end, string_end: out_bus.string_end};
        if (expected_units.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_LIMIT)
            $display("unexpected beat: unit %h err %0d run_end %b string_end %b",
                     got.code_unit, got.error_code, got.run_end, got.string_end);
        end else begin
          want = expected_units.pop_front();
          if (got.code_unit !== want.code_unit || got.error_code !== want.error_code ||
              got.run_end !== want.run_end || got.string_end !== want.string_end) begin
            n_errors++;
            if (n_errors <= REPORT_LIMIT)
              $display("mismatch: expected unit %h err %0d run_end %b string_end %b, %s",
                       want.code_unit, want.error_code, want.run_end, want.string_end,
                       $sformatf("got unit %h err %0d run_end %b string_end %b",
                                 got.code_unit, got.error_code, got.run_end,
                                 got.string_end));
          end
        end
      end
      if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left <= LONG_HOLD;
        out_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run if neither channel moves a beat for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("[utf8_to_utf16_decoder] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Phases of idling: none, sender idle, receiver stalling, both. The first phase
  // runs the directed strings and the long receiver hold with the sender at full
  // rate. Between phases the sender pauses until every expected unit has arrived.
  int send_idle_tbl[4] = '{0, 58, 0, 36};
  int recv_stall_tbl[4] = '{0, 0, 58, 36};

  initial begin
    int phase_start;
    in_bus.valid = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.final_byte = 1'b0;
    out_bus.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_tbl[ph];
      recv_stall_pct = recv_stall_tbl[ph];
      phase_start = bytes_queued;
      if (ph == 0) queue_directed();
      while (bytes_queued - phase_start < PHASE_BYTES) queue_string();
      if (ph == 0) hold_requests++;
      while (bytes_accepted != bytes_queued) @(posedge clk);
      while (expected_units.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && expected_units.size() == 0) begin
      $display("[utf8_to_utf16_decoder] OK");
    end else begin
      $display("[utf8_to_utf16_decoder] ERROR");
    end
    $finish;
  end

endmodule
